// ===== sv/bfm_pkg.sv =====
// Shared types, constants and helpers of the compile-and-execute machine.
package bfm_pkg;

  localparam int MEM_AW      = 15;
  localparam int MEM_DEPTH   = 2 ** MEM_AW;
  localparam int PROG_AW     = 12;
  localparam int PROG_DEPTH  = 2 ** PROG_AW;
  localparam int STACK_AW    = 8;
  localparam int STACK_DEPTH = 2 ** STACK_AW;
  localparam int OPC_W       = 4;
  localparam int ARG_W       = MEM_AW;
  localparam int INSTR_W     = OPC_W + ARG_W;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LBR   = 8'h5B;
  localparam logic [7:0] CH_RBR   = 8'h5D;

  typedef enum logic [1:0] {
    CMD_COMPILE, CMD_FINISH, CMD_STEP, CMD_NOP
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK, ST_UNMATCHED_CLOSE, ST_UNMATCHED_OPEN, ST_PROG_FULL, ST_STACK_FULL,
    ST_WRONG_PHASE
  } status_e;

  typedef enum logic [OPC_W-1:0] {
    OPC_ADD, OPC_SUB, OPC_RIGHT, OPC_LEFT, OPC_OUT, OPC_IN, OPC_OPEN, OPC_CLOSE,
    OPC_HALT
  } opc_e;

  typedef enum logic [3:0] {
    CC_ADD, CC_SUB, CC_RIGHT, CC_LEFT, CC_OUT, CC_IN, CC_OPEN, CC_CLOSE, CC_OTHER
  } char_cls_e;

  typedef enum logic [3:0] {
    DP_NONE, DP_LATCH, DP_CLEAR, DP_RD_LAST, DP_RUN_INC, DP_APPEND, DP_POP,
    DP_PATCH, DP_PREV, DP_STATUS, DP_ERR, DP_RD_EXEC, DP_EXEC, DP_RD_FLAGS,
    DP_FLAGS, DP_PUSH
  } dp_op_e;

  typedef struct packed {
    dp_op_e  op;
    status_e code;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e      cmd;
    char_cls_e cls;
    logic      prev_match;
    logic      ic_full;
    logic      depth_zero;
    logic      depth_full;
    logic      compiled;
    logic      err_set;
    logic      ea_past_end;
    logic      clear_last;
    logic      out_free;
    status_e   err;
  } dp_stat_t;

  function automatic char_cls_e classify(logic [7:0] c);
    char_cls_e r;
    case (c)
      CH_PLUS:  r = CC_ADD;
      CH_MINUS: r = CC_SUB;
      CH_GT:    r = CC_RIGHT;
      CH_LT:    r = CC_LEFT;
      CH_DOT:   r = CC_OUT;
      CH_COMMA: r = CC_IN;
      CH_LBR:   r = CC_OPEN;
      CH_RBR:   r = CC_CLOSE;
      default:  r = CC_OTHER;
    endcase
    return r;
  endfunction

  function automatic logic is_run(char_cls_e c);
    return (c == CC_ADD) || (c == CC_SUB) || (c == CC_RIGHT) || (c == CC_LEFT);
  endfunction

endpackage

// ===== sv/bfm_dpath.sv =====
// Datapath with program, data and bracket stores, machine registers and result registers.
module bfm_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bfm_pkg::dp_cmd_t  cmd_i,
  output bfm_pkg::dp_stat_t stat_o,
  input  logic [1:0]        item_cmd_i,
  input  logic [7:0]        src_char_i,
  input  logic [7:0]        in_byte_i,
  input  logic              out_ready_i,
  output logic              out_pend_o,
  output logic [2:0]        status_o,
  output logic              out_valid_o,
  output logic [7:0]        out_byte_o,
  output logic              halted_o,
  output logic              next_is_read_o
);
  import bfm_pkg::*;

  logic [INSTR_W-1:0]  prog_mem  [PROG_DEPTH];
  logic [7:0]          data_mem  [MEM_DEPTH];
  logic [PROG_AW-1:0]  stack_mem [STACK_DEPTH];

  cmd_e               cmd_q;
  logic [7:0]         src_q;
  logic [7:0]         inb_q;
  logic [PROG_AW:0]   ic_q;
  logic [STACK_AW:0]  depth_q;
  logic [PROG_AW:0]   ea_q;
  logic [MEM_AW-1:0]  dp_q;
  char_cls_e          prev_q;
  logic               compiled_q;
  status_e            err_q;
  logic [MEM_AW-1:0]  clr_q;
  logic [INSTR_W-1:0] prog_rd_q;
  logic [7:0]         data_rd_q;
  logic [PROG_AW-1:0] stack_rd_q;
  status_e            res_status_q;
  logic               res_valid_q;
  logic [7:0]         res_byte_q;
  logic               res_halt_q;
  logic               res_rd_q;
  status_e            o_status_q;
  logic               o_valid_q;
  logic [7:0]         o_byte_q;
  logic               o_halt_q;
  logic               o_rd_q;
  logic               o_pend_q;

  char_cls_e          cls;
  opc_e               pr_op;
  logic [ARG_W-1:0]   pr_arg;
  logic [ARG_W-1:0]   arg_inc;
  logic [PROG_AW:0]   ic_last;
  logic [STACK_AW:0]  depth_m1;
  opc_e               app_op;
  logic [ARG_W-1:0]   app_arg;
  logic               prog_we, prog_re, data_we, data_re, stack_we, stack_re;
  logic [PROG_AW-1:0] prog_waddr, prog_raddr;
  logic [INSTR_W-1:0] prog_wdata;
  logic [MEM_AW-1:0]  data_addr;
  logic [7:0]         data_wdata;
  logic [STACK_AW-1:0] stack_addr;

  assign cls      = classify(src_q);
  assign pr_op    = opc_e'(prog_rd_q[INSTR_W-1 -: OPC_W]);
  assign pr_arg   = prog_rd_q[ARG_W-1:0];
  assign arg_inc  = pr_arg + ARG_W'(1);
  assign ic_last  = ic_q - (PROG_AW+1)'(1);
  assign depth_m1 = depth_q - (STACK_AW+1)'(1);

  always_comb begin
    app_op  = OPC_HALT;
    app_arg = '0;
    if (cmd_q == CMD_COMPILE) begin
      case (cls)
        CC_ADD:   begin app_op = OPC_ADD;   app_arg = ARG_W'(1); end
        CC_SUB:   begin app_op = OPC_SUB;   app_arg = ARG_W'(1); end
        CC_RIGHT: begin app_op = OPC_RIGHT; app_arg = ARG_W'(1); end
        CC_LEFT:  begin app_op = OPC_LEFT;  app_arg = ARG_W'(1); end
        CC_OUT:   app_op = OPC_OUT;
        CC_IN:    app_op = OPC_IN;
        CC_OPEN:  app_op = OPC_OPEN;
        CC_CLOSE: begin
          app_op  = OPC_CLOSE;
          app_arg = ARG_W'(stack_rd_q) + ARG_W'(1);
        end
        default:  app_op = OPC_HALT;
      endcase
    end
  end

  always_comb begin
    prog_we    = 1'b0;
    prog_re    = 1'b0;
    data_we    = 1'b0;
    data_re    = 1'b0;
    stack_we   = 1'b0;
    stack_re   = 1'b0;
    prog_waddr = ic_q[PROG_AW-1:0];
    prog_raddr = ea_q[PROG_AW-1:0];
    prog_wdata = {app_op, app_arg};
    data_addr  = dp_q;
    data_wdata = '0;
    stack_addr = depth_q[STACK_AW-1:0];
    unique case (cmd_i.op)
      DP_CLEAR: begin
        data_we   = 1'b1;
        data_addr = clr_q;
      end
      DP_RD_LAST: begin
        prog_re    = 1'b1;
        prog_raddr = ic_last[PROG_AW-1:0];
      end
      DP_RUN_INC: begin
        prog_we    = 1'b1;
        prog_waddr = ic_last[PROG_AW-1:0];
        if (cls == CC_ADD || cls == CC_SUB) begin
          prog_wdata = {pr_op, ARG_W'(arg_inc[7:0])};
        end else begin
          prog_wdata = {pr_op, arg_inc};
        end
      end
      DP_APPEND: begin
        prog_we = 1'b1;
        if (cmd_q == CMD_COMPILE && cls == CC_OPEN) begin
          stack_we = 1'b1;
        end
      end
      DP_POP: begin
        stack_re   = 1'b1;
        stack_addr = depth_m1[STACK_AW-1:0];
      end
      DP_PATCH: begin
        prog_we    = 1'b1;
        prog_waddr = stack_rd_q;
        prog_wdata = {OPC_OPEN, ARG_W'(ic_q) + ARG_W'(1)};
      end
      DP_RD_EXEC: begin
        prog_re = 1'b1;
        data_re = 1'b1;
      end
      DP_EXEC: begin
        case (pr_op)
          OPC_ADD: begin data_we = 1'b1; data_wdata = data_rd_q + pr_arg[7:0]; end
          OPC_SUB: begin data_we = 1'b1; data_wdata = data_rd_q - pr_arg[7:0]; end
          OPC_IN:  begin data_we = 1'b1; data_wdata = inb_q; end
          default: data_we = 1'b0;
        endcase
      end
      DP_RD_FLAGS: prog_re = 1'b1;
      default: prog_re = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (prog_we) begin
      prog_mem[prog_waddr] <= prog_wdata;
    end
    if (prog_re) begin
      prog_rd_q <= prog_mem[prog_raddr];
    end
    if (data_we) begin
      data_mem[data_addr] <= data_wdata;
    end
    if (data_re) begin
      data_rd_q <= data_mem[data_addr];
    end
    if (stack_we) begin
      stack_mem[stack_addr] <= ic_q[PROG_AW-1:0];
    end
    if (stack_re) begin
      stack_rd_q <= stack_mem[stack_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_pend_q <= 1'b0;
    end else if (cmd_i.op == DP_PUSH) begin
      o_pend_q <= 1'b1;
    end else if (out_ready_i) begin
      o_pend_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q        <= CMD_NOP;
      src_q        <= '0;
      inb_q        <= '0;
      ic_q         <= '0;
      depth_q      <= '0;
      ea_q         <= '0;
      dp_q         <= '0;
      prev_q       <= CC_OTHER;
      compiled_q   <= 1'b0;
      err_q        <= ST_OK;
      clr_q        <= '0;
      res_status_q <= ST_OK;
      res_valid_q  <= 1'b0;
      res_byte_q   <= '0;
      res_halt_q   <= 1'b0;
      res_rd_q     <= 1'b0;
      o_status_q   <= ST_OK;
      o_valid_q    <= 1'b0;
      o_byte_q     <= '0;
      o_halt_q     <= 1'b0;
      o_rd_q       <= 1'b0;
    end else begin
      unique case (cmd_i.op)
        DP_LATCH: begin
          cmd_q        <= cmd_e'(item_cmd_i);
          src_q        <= src_char_i;
          inb_q        <= in_byte_i;
          res_status_q <= ST_OK;
          res_valid_q  <= 1'b0;
          res_byte_q   <= '0;
          res_halt_q   <= 1'b0;
          res_rd_q     <= 1'b0;
        end
        DP_CLEAR: clr_q <= clr_q + MEM_AW'(1);
        DP_APPEND: begin
          ic_q <= ic_q + (PROG_AW+1)'(1);
          if (cmd_q == CMD_FINISH) begin
            compiled_q <= 1'b1;
          end else if (cls == CC_OPEN) begin
            depth_q <= depth_q + (STACK_AW+1)'(1);
          end
        end
        DP_POP:    depth_q <= depth_m1;
        DP_PREV:   prev_q <= is_run(cls) ? cls : CC_OTHER;
        DP_STATUS: res_status_q <= cmd_i.code;
        DP_ERR: begin
          err_q        <= cmd_i.code;
          res_status_q <= cmd_i.code;
        end
        DP_EXEC: begin
          case (pr_op)
            OPC_ADD, OPC_SUB, OPC_IN: ea_q <= ea_q + (PROG_AW+1)'(1);
            OPC_RIGHT: begin
              dp_q <= dp_q + pr_arg[MEM_AW-1:0];
              ea_q <= ea_q + (PROG_AW+1)'(1);
            end
            OPC_LEFT: begin
              dp_q <= dp_q - pr_arg[MEM_AW-1:0];
              ea_q <= ea_q + (PROG_AW+1)'(1);
            end
            OPC_OUT: begin
              res_valid_q <= 1'b1;
              res_byte_q  <= data_rd_q;
              ea_q        <= ea_q + (PROG_AW+1)'(1);
            end
            OPC_OPEN: begin
              ea_q <= (data_rd_q == 8'd0) ? pr_arg[PROG_AW:0] : ea_q + (PROG_AW+1)'(1);
            end
            OPC_CLOSE: begin
              ea_q <= (data_rd_q != 8'd0) ? pr_arg[PROG_AW:0] : ea_q + (PROG_AW+1)'(1);
            end
            default: ea_q <= ea_q;
          endcase
        end
        DP_FLAGS: begin
          if (ea_q >= ic_q) begin
            res_halt_q <= 1'b1;
            res_rd_q   <= 1'b0;
          end else begin
            res_halt_q <= (pr_op == OPC_HALT);
            res_rd_q   <= (pr_op == OPC_IN);
          end
        end
        DP_PUSH: begin
          o_status_q <= res_status_q;
          o_valid_q  <= res_valid_q;
          o_byte_q   <= res_byte_q;
          o_halt_q   <= res_halt_q;
          o_rd_q     <= res_rd_q;
        end
        default: cmd_q <= cmd_q;
      endcase
    end
  end

  always_comb begin
    stat_o.cmd         = cmd_q;
    stat_o.cls         = cls;
    stat_o.prev_match  = is_run(cls) && (prev_q == cls) && (ic_q != '0);
    stat_o.ic_full     = ic_q[PROG_AW];
    stat_o.depth_zero  = (depth_q == '0);
    stat_o.depth_full  = depth_q[STACK_AW];
    stat_o.compiled    = compiled_q;
    stat_o.err_set     = (err_q != ST_OK);
    stat_o.ea_past_end = (ea_q >= ic_q);
    stat_o.clear_last  = &clr_q;
    stat_o.out_free    = !o_pend_q || out_ready_i;
    stat_o.err         = err_q;
  end

  assign out_pend_o     = o_pend_q;
  assign status_o       = o_status_q;
  assign out_valid_o    = o_valid_q;
  assign out_byte_o     = o_byte_q;
  assign halted_o       = o_halt_q;
  assign next_is_read_o = o_rd_q;

endmodule

// ===== sv/bfm_ctrl.sv =====
// Controller state machine that sequences compile, finish and step requests.
module bfm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bfm_pkg::dp_stat_t stat_i,
  output bfm_pkg::dp_cmd_t  cmd_o
);
  import bfm_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_RUN_RD, S_RUN_WR, S_POP, S_PATCH, S_APPEND,
    S_PREV, S_ERR, S_EXEC_RD, S_EXEC, S_FLAG_RD, S_FLAG, S_DONE
  } state_e;

  state_e  state_q, state_d;
  status_e code_q, code_d;

  always_comb begin
    state_d     = state_q;
    code_d      = code_q;
    in_ready_o  = 1'b0;
    cmd_o.op    = DP_NONE;
    cmd_o.code  = code_q;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.op = DP_CLEAR;
        if (stat_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = DP_LATCH;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat_i.err_set) begin
          cmd_o.op   = DP_STATUS;
          cmd_o.code = stat_i.err;
          state_d    = S_DONE;
        end else begin
          unique case (stat_i.cmd)
            CMD_COMPILE: begin
              if (stat_i.compiled) begin
                cmd_o.op   = DP_STATUS;
                cmd_o.code = ST_WRONG_PHASE;
                state_d    = S_FLAG_RD;
              end else begin
                case (stat_i.cls) inside
                  CC_ADD, CC_SUB, CC_RIGHT, CC_LEFT: begin
                    if (stat_i.prev_match) begin
                      state_d = S_RUN_RD;
                    end else if (stat_i.ic_full) begin
                      code_d = ST_PROG_FULL; state_d = S_ERR;
                    end else begin
                      state_d = S_APPEND;
                    end
                  end
                  CC_OUT, CC_IN: begin
                    if (stat_i.ic_full) begin
                      code_d = ST_PROG_FULL; state_d = S_ERR;
                    end else begin
                      state_d = S_APPEND;
                    end
                  end
                  CC_OPEN: begin
                    if (stat_i.ic_full) begin
                      code_d = ST_PROG_FULL; state_d = S_ERR;
                    end else if (stat_i.depth_full) begin
                      code_d = ST_STACK_FULL; state_d = S_ERR;
                    end else begin
                      state_d = S_APPEND;
                    end
                  end
                  CC_CLOSE: begin
                    if (stat_i.depth_zero) begin
                      code_d = ST_UNMATCHED_CLOSE; state_d = S_ERR;
                    end else if (stat_i.ic_full) begin
                      code_d = ST_PROG_FULL; state_d = S_ERR;
                    end else begin
                      state_d = S_POP;
                    end
                  end
                  default: state_d = S_PREV;
                endcase
              end
            end
            CMD_FINISH: begin
              if (stat_i.compiled) begin
                cmd_o.op   = DP_STATUS;
                cmd_o.code = ST_WRONG_PHASE;
                state_d    = S_FLAG_RD;
              end else if (stat_i.ic_full) begin
                code_d  = ST_PROG_FULL;
                state_d = S_ERR;
              end else begin
                state_d = S_APPEND;
              end
            end
            CMD_STEP: begin
              if (!stat_i.compiled) begin
                cmd_o.op   = DP_STATUS;
                cmd_o.code = ST_WRONG_PHASE;
                state_d    = S_DONE;
              end else if (stat_i.ea_past_end) begin
                state_d = S_FLAG_RD;
              end else begin
                state_d = S_EXEC_RD;
              end
            end
            default: state_d = stat_i.compiled ? S_FLAG_RD : S_DONE;
          endcase
        end
      end
      S_RUN_RD: begin
        cmd_o.op = DP_RD_LAST;
        state_d  = S_RUN_WR;
      end
      S_RUN_WR: begin
        cmd_o.op = DP_RUN_INC;
        state_d  = S_PREV;
      end
      S_POP: begin
        cmd_o.op = DP_POP;
        state_d  = S_PATCH;
      end
      S_PATCH: begin
        cmd_o.op = DP_PATCH;
        state_d  = S_APPEND;
      end
      S_APPEND: begin
        cmd_o.op = DP_APPEND;
        if (stat_i.cmd == CMD_FINISH) begin
          if (stat_i.depth_zero) begin
            state_d = S_FLAG_RD;
          end else begin
            code_d  = ST_UNMATCHED_OPEN;
            state_d = S_ERR;
          end
        end else begin
          state_d = S_PREV;
        end
      end
      S_PREV: begin
        cmd_o.op = DP_PREV;
        state_d  = S_DONE;
      end
      S_ERR: begin
        cmd_o.op = DP_ERR;
        state_d  = S_DONE;
      end
      S_EXEC_RD: begin
        cmd_o.op = DP_RD_EXEC;
        state_d  = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.op = DP_EXEC;
        state_d  = S_FLAG_RD;
      end
      S_FLAG_RD: begin
        cmd_o.op = DP_RD_FLAGS;
        state_d  = S_FLAG;
      end
      S_FLAG: begin
        cmd_o.op = DP_FLAGS;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.op = DP_PUSH;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      code_q  <= ST_OK;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

endmodule

// ===== sv/bf_compile_and_execute_machine_unit.sv =====
// Top level of the run-length compiling interpreter: stream ports, controller and datapath.
// After reset the unit clears its 32768-byte data store, one cell a cycle, and accepts no
// request until the clear is done. It then handles one request at a time. A step request
// passes through the registered reads of the program store: one read to fetch the
// instruction and its data cell (skipped once the program has run off its end), one to
// fetch the next instruction for the halted and next-is-read flags (both skipped before
// finish). A result waits in an output register, so the next request is taken while it
// is still pending on the master side.
module bf_compile_and_execute_machine_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // cmd[1:0], src_char[9:2], in_byte[17:10], zero fill
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // status[2:0], out_valid[3], out_byte[11:4],
                                      // halted[12], next_is_read[13], zero fill
);
  import bfm_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_stat_t   dp_stat;
  logic [2:0] status;
  logic       out_flag;
  logic [7:0] out_byte;
  logic       halted;
  logic       next_rd;

  bfm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  bfm_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .stat_o         (dp_stat),
    .item_cmd_i     (s_axis_tdata[1:0]),
    .src_char_i     (s_axis_tdata[9:2]),
    .in_byte_i      (s_axis_tdata[17:10]),
    .out_ready_i    (m_axis_tready),
    .out_pend_o     (m_axis_tvalid),
    .status_o       (status),
    .out_valid_o    (out_flag),
    .out_byte_o     (out_byte),
    .halted_o       (halted),
    .next_is_read_o (next_rd)
  );

  assign m_axis_tdata = {2'b00, next_rd, halted, out_byte, out_flag, status};

  // A request in progress keeps the input side closed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a request was in progress");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[2:0] != 3'd6 && m_axis_tdata[2:0] != 3'd7)
    else $error("undefined status code");

  // An emitted byte only comes from a successful step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[2:0] == ST_OK)
    else $error("output byte with error status");

endmodule

// ===== test/tb_bf_compile_and_execute_machine_unit.sv =====
// Testbench for the run-length compiling interpreter, with stream stimulus and a request-level predictor.
`timescale 1ns / 100ps

module tb_bf_compile_and_execute_machine_unit;
  import bfm_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;

  bf_compile_and_execute_machine_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  typedef struct packed {
    logic       next_is_read;
    logic       halted;
    logic [7:0] out_byte;
    logic       out_valid;
    status_e    status;
  } bf_result_t;

  logic [23:0] pending_requests[$];
  bf_result_t  expected_results[$];
  int          error_count = 0;
  int          accepted_count = 0;
  int          cycle_count = 0;

  // Predictor state.
  opc_e       prog_op[PROG_DEPTH];
  int         prog_arg[PROG_DEPTH];
  logic [7:0] cells[MEM_DEPTH];
  int         bracket_addr[STACK_DEPTH];
  int         depth, icount, pc, dptr;
  char_cls_e  last_run;
  bit         compiled;
  status_e    latched_err;

  initial begin
    foreach (cells[i]) cells[i] = 8'd0;
    depth = 0; icount = 0; pc = 0; dptr = 0;
    last_run = CC_OTHER; compiled = 1'b0; latched_err = ST_OK;
  end

  function automatic bit add_instr(opc_e op, int arg);
    if (icount >= PROG_DEPTH) return 1'b0;
    prog_op[icount] = op;
    prog_arg[icount] = arg;
    icount++;
    return 1'b1;
  endfunction

  function automatic status_e compile_char(logic [7:0] c);
    char_cls_e cls;
    int        lim;
    int        open_at;
    cls = classify(c);
    if (is_run(cls)) begin
      lim = (cls == CC_ADD || cls == CC_SUB) ? 256 : MEM_DEPTH;
      if (last_run == cls && icount > 0) begin
        prog_arg[icount-1] = (prog_arg[icount-1] + 1) % lim;
      end else if (!add_instr(opc_e'(cls), 1)) begin
        return ST_PROG_FULL;
      end
      last_run = cls;
      return ST_OK;
    end
    last_run = CC_OTHER;
    case (cls)
      CC_OUT: return add_instr(OPC_OUT, 0) ? ST_OK : ST_PROG_FULL;
      CC_IN:  return add_instr(OPC_IN, 0) ? ST_OK : ST_PROG_FULL;
      CC_OPEN: begin
        if (icount >= PROG_DEPTH) return ST_PROG_FULL;
        if (depth >= STACK_DEPTH) return ST_STACK_FULL;
        bracket_addr[depth++] = icount;
        void'(add_instr(OPC_OPEN, 0));
        return ST_OK;
      end
      CC_CLOSE: begin
        if (depth == 0) return ST_UNMATCHED_CLOSE;
        if (icount >= PROG_DEPTH) return ST_PROG_FULL;
        open_at = bracket_addr[--depth];
        prog_arg[open_at] = icount + 1;
        void'(add_instr(OPC_CLOSE, open_at + 1));
        return ST_OK;
      end
      default: return ST_OK;
    endcase
  endfunction

  function automatic bf_result_t predict_result(logic [23:0] req);
    cmd_e       cmd;
    logic [7:0] src, inb;
    bf_result_t r;
    cmd = cmd_e'(req[1:0]);
    src = req[9:2];
    inb = req[17:10];
    r = '0;
    if (latched_err != ST_OK) begin
      r.status = latched_err;
    end else if (cmd == CMD_COMPILE) begin
      if (compiled) r.status = ST_WRONG_PHASE;
      else begin
        latched_err = compile_char(src);
        r.status = latched_err;
      end
    end else if (cmd == CMD_FINISH) begin
      if (compiled) r.status = ST_WRONG_PHASE;
      else begin
        compiled = 1'b1;
        if (!add_instr(OPC_HALT, 0)) latched_err = ST_PROG_FULL;
        else if (depth != 0) latched_err = ST_UNMATCHED_OPEN;
        r.status = latched_err;
      end
    end else if (cmd == CMD_STEP) begin
      if (!compiled) r.status = ST_WRONG_PHASE;
      else if (pc < icount) begin
        case (prog_op[pc])
          OPC_ADD:   begin cells[dptr] += prog_arg[pc][7:0]; pc++; end
          OPC_SUB:   begin cells[dptr] -= prog_arg[pc][7:0]; pc++; end
          OPC_RIGHT: begin dptr = (dptr + prog_arg[pc]) % MEM_DEPTH; pc++; end
          OPC_LEFT:  begin dptr = (dptr + MEM_DEPTH - prog_arg[pc]) % MEM_DEPTH; pc++; end
          OPC_OUT:   begin r.out_valid = 1'b1; r.out_byte = cells[dptr]; pc++; end
          OPC_IN:    begin cells[dptr] = inb; pc++; end
          OPC_OPEN:  pc = (cells[dptr] == 8'd0) ? prog_arg[pc] : pc + 1;
          OPC_CLOSE: pc = (cells[dptr] != 8'd0) ? prog_arg[pc] : pc + 1;
          default: ;
        endcase
      end
    end
    if (compiled && latched_err == ST_OK) begin
      if (pc >= icount) r.halted = 1'b1;
      else begin
        r.halted = (prog_op[pc] == OPC_HALT);
        r.next_is_read = (prog_op[pc] == OPC_IN);
      end
    end
    return r;
  endfunction

  // Stimulus construction.
  task automatic push_request(cmd_e cmd, logic [7:0] src, logic [7:0] inb);
    pending_requests.push_back({6'd0, inb, src, cmd});
  endtask

  task automatic push_char(logic [7:0] c);
    push_request(CMD_COMPILE, c, 8'($urandom));
  endtask

  function automatic logic [7:0] random_char();
    case ($urandom_range(0, 9))
      0, 1: return CH_PLUS;
      2:    return CH_MINUS;
      3:    return CH_GT;
      4:    return CH_LT;
      5:    return CH_DOT;
      6:    return CH_COMMA;
      7:    return 8'($urandom);
      default: return CH_MINUS;
    endcase
  endfunction

  task automatic build_stimulus();
    logic [7:0] any_src;
    int         mode, nest, n;
    mode = $urandom_range(0, 9);
    push_request(CMD_STEP, 8'($urandom), 8'($urandom));
    push_request(CMD_NOP, 8'hFF, 8'hFF);
    push_char(8'h00);
    push_char(8'hFF);
    if (mode == 0) begin
      push_char(CH_PLUS);
      push_char(CH_RBR);
      while (pending_requests.size() < 1100) begin
        any_src = random_char();
        push_request(cmd_e'($urandom_range(0, 3)), any_src, 8'($urandom));
      end
      return;
    end
    if (mode == 1) begin
      for (int i = 0; i < STACK_DEPTH + 1; i++) push_char(CH_LBR);
      while (pending_requests.size() < 1100)
        push_request(cmd_e'($urandom_range(0, 3)), CH_RBR, 8'($urandom));
      return;
    end
    if (mode == 3) begin
      push_char(CH_COMMA);
      push_char(CH_LBR);
      push_char(CH_MINUS);
      push_request(CMD_FINISH, 8'($urandom), 8'($urandom));
      while (pending_requests.size() < 1100)
        push_request(cmd_e'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
      return;
    end
    // Well-formed program: every command, a wrapping '+' run, nested loops.
    push_char(CH_LT);
    push_char(CH_LT);
    push_char(CH_DOT);
    push_char(CH_COMMA);
    push_char(CH_DOT);
    push_char(CH_LBR);
    push_char(CH_MINUS);
    push_char(CH_RBR);
    for (int i = 0; i < 258; i++) push_char(CH_PLUS);
    push_char(CH_DOT);
    push_char(CH_GT);
    push_char(CH_GT);
    push_char(CH_PLUS);
    push_char(CH_LBR);
    nest = 1;
    n = $urandom_range(120, 220);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: if (nest < 8) begin
          push_char(CH_LBR);
          push_char(CH_MINUS);
          nest++;
        end
        1: if (nest > 0) begin
          push_char(CH_RBR);
          nest--;
        end
        default: push_char(random_char());
      endcase
    end
    while (nest > 0) begin
      push_char(CH_RBR);
      nest--;
    end
    push_request(CMD_FINISH, 8'($urandom), 8'($urandom));
    push_request(CMD_FINISH, 8'($urandom), 8'($urandom));
    push_char(CH_PLUS);
    push_request(CMD_STEP, 8'($urandom), 8'hFF);
    for (int i = 0; i < 650; i++) begin
      if ($urandom_range(0, 9) == 0)
        push_request(cmd_e'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
      else
        push_request(CMD_STEP, 8'($urandom),
                     ($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom));
    end
  endtask

  // Pressure phases cycle every 150 requests: none, sender, receiver, both.
  function automatic bit hold_off(bit sender);
    int phase;
    phase = (accepted_count / 150) % 4;
    if (phase == 3) return $urandom_range(0, 99) < 25;
    if (phase == (sender ? 1 : 2)) return $urandom_range(0, 99) < 51;
    return 1'b0;
  endfunction

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        expected_results.push_back(predict_result(s_axis_tdata));
        accepted_count++;
      end
      if (pending_requests.size() > 0 && !hold_off(1'b1)) begin
        s_axis_tdata  <= pending_requests.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    bf_result_t got, want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[13:0];
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            error_count++;
          end
          if (got.out_valid !== want.out_valid) begin
            $display("%0t: out_valid expected %b actual %b", $time, want.out_valid,
                     got.out_valid);
            error_count++;
          end
          if (got.out_byte !== want.out_byte) begin
            $display("%0t: out_byte expected %h actual %h", $time, want.out_byte,
                     got.out_byte);
            error_count++;
          end
          if (got.halted !== want.halted) begin
            $display("%0t: halted expected %b actual %b", $time, want.halted, got.halted);
            error_count++;
          end
          if (got.next_is_read !== want.next_is_read) begin
            $display("%0t: next_is_read expected %b actual %b", $time, want.next_is_read,
                     got.next_is_read);
            error_count++;
          end
        end
      end
      m_axis_tready <= !hold_off(1'b0);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 1500000) begin
      $display("[bf_compile_and_execute_machine_unit] ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    build_stimulus();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_requests.size() == 0 && !s_axis_tvalid && expected_results.size() == 0);
    repeat (40) @(posedge clk_i);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("[bf_compile_and_execute_machine_unit] OK");
    end else begin
      $display("[bf_compile_and_execute_machine_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/bfm_pkg.sv
sv/bfm_dpath.sv
sv/bfm_ctrl.sv
sv/bf_compile_and_execute_machine_unit.sv
test/tb_bf_compile_and_execute_machine_unit.sv
